// ----- rtl/tmbd_pkg.sv -----
// ----------------------------------------------------------------------------
// tmbd_pkg
// shared constants, field widths, state and control types of the touch
// matrix baseline detector
// ----------------------------------------------------------------------------
package tmbd_pkg;

  // default geometry
  localparam int NUM_STRINGS_DEF   = 6;
  localparam int NUM_FRETS_DEF     = 7;
  localparam int HISTORY_WIDTH_DEF = 8;

  // field widths
  localparam int STRING_W   = 3;
  localparam int FRET_W     = 3;
  localparam int COUNT_W    = 16;
  localparam int HIST_OUT_W = 8;
  localparam int MASK_OUT_W = 7;

  // arithmetic widths
  localparam int BASE_W    = 17;
  localparam int WEIGHT_W  = 8;
  localparam int PROD_W    = BASE_W + WEIGHT_W;
  localparam int ACC_W     = PROD_W + 1;
  localparam int DIVISOR_W = WEIGHT_W + 1;
  localparam int DIV_CNT_W = $clog2(ACC_W);

  // stream widths
  localparam int S_TDATA_W = 24;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 24;

  // constants
  localparam logic [BASE_W-1:0]   MISSING_COUNT   = 17'd99999;
  localparam logic [BASE_W-1:0]   THRESHOLD_RESET = 17'd200;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET    = 8'd50;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = BASE_W;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT    = 1'b1;

  // item kinds
  localparam logic ACTION_EVALUATE = 1'b0;
  localparam logic ACTION_LOAD     = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_CALC,
    ST_DIVIDE,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic read;
    logic load_write;
    logic calc;
    logic div_step;
    logic update;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_range;
    logic is_load;
    logic touch_hit;
    logic div_done;
    logic last_fret;
    logic out_busy;
  } ctrl_status_t;

endpackage

// ----- rtl/tmbd_ram.sv -----
// ----------------------------------------------------------------------------
// tmbd_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module tmbd_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 42,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/tmbd_ctrl.sv -----
// ----------------------------------------------------------------------------
// tmbd_ctrl
// item sequencer: lookup, compare, serial divide, update and result hand-off
// ----------------------------------------------------------------------------
module tmbd_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  tmbd_pkg::ctrl_status_t status,
  output tmbd_pkg::ctrl_cmd_t    cmd
);

  tmbd_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tmbd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tmbd_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = tmbd_pkg::ST_LOOKUP;
      end
      tmbd_pkg::ST_LOOKUP: begin
        if (!status.in_range || status.is_load) state_next = tmbd_pkg::ST_IDLE;
        else state_next = tmbd_pkg::ST_CALC;
      end
      tmbd_pkg::ST_CALC: begin
        if (status.touch_hit) state_next = tmbd_pkg::ST_UPDATE;
        else state_next = tmbd_pkg::ST_DIVIDE;
      end
      tmbd_pkg::ST_DIVIDE: begin
        if (status.div_done) state_next = tmbd_pkg::ST_UPDATE;
      end
      tmbd_pkg::ST_UPDATE: begin
        if (status.last_fret) state_next = tmbd_pkg::ST_EMIT;
        else state_next = tmbd_pkg::ST_IDLE;
      end
      tmbd_pkg::ST_EMIT: begin
        if (!status.out_busy) state_next = tmbd_pkg::ST_IDLE;
      end
      default: state_next = tmbd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      tmbd_pkg::ST_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
      end
      tmbd_pkg::ST_LOOKUP: begin
        cmd.load_write = status.in_range && status.is_load;
        cmd.read       = status.in_range && !status.is_load;
      end
      tmbd_pkg::ST_CALC: begin
        cmd.calc = 1'b1;
      end
      tmbd_pkg::ST_DIVIDE: begin
        cmd.div_step = 1'b1;
      end
      tmbd_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
      end
      tmbd_pkg::ST_EMIT: begin
        cmd.emit = !status.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- rtl/tmbd_datapath.sv -----
// ----------------------------------------------------------------------------
// tmbd_datapath
// item registers, baseline memory, threshold compare, averaging divider,
// touch mask, per-string history and output register
// ----------------------------------------------------------------------------
module tmbd_datapath #(
  parameter int NUM_STRINGS   = tmbd_pkg::NUM_STRINGS_DEF,
  parameter int NUM_FRETS     = tmbd_pkg::NUM_FRETS_DEF,
  parameter int HISTORY_WIDTH = tmbd_pkg::HISTORY_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  tmbd_pkg::ctrl_cmd_t             cmd,
  output tmbd_pkg::ctrl_status_t          status,
  input  logic [tmbd_pkg::S_TDATA_W-1:0]  s_tdata,
  input  logic [tmbd_pkg::S_TUSER_W-1:0]  s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [tmbd_pkg::M_TDATA_W-1:0]  m_tdata,
  input  logic                            cfg_we,
  input  logic [tmbd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tmbd_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int NUM_CELLS = NUM_STRINGS * NUM_FRETS;
  localparam int CELL_W    = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int STR_IDX_W = (NUM_STRINGS > 1) ? $clog2(NUM_STRINGS) : 1;

  // configuration
  logic [tmbd_pkg::BASE_W-1:0]   touch_threshold;
  logic [tmbd_pkg::WEIGHT_W-1:0] filter_weight;

  always_ff @(posedge clk) begin
    if (rst) begin
      touch_threshold <= tmbd_pkg::THRESHOLD_RESET;
      filter_weight   <= tmbd_pkg::WEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tmbd_pkg::REG_THRESHOLD: touch_threshold <= cfg_data;
        tmbd_pkg::REG_WEIGHT:    filter_weight <= cfg_data[tmbd_pkg::WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // item registers
  logic                           action;
  logic                           captured;
  logic [tmbd_pkg::STRING_W-1:0]  string_idx;
  logic [tmbd_pkg::FRET_W-1:0]    fret_idx;
  logic [tmbd_pkg::COUNT_W-1:0]   capture_count;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      action        <= s_tuser[0];
      captured      <= s_tuser[1];
      string_idx    <= s_tdata[2:0];
      fret_idx      <= s_tdata[5:3];
      capture_count <= s_tdata[21:6];
    end
  end

  logic [tmbd_pkg::BASE_W-1:0] sample;
  logic [CELL_W-1:0]           cell_addr;
  logic [STR_IDX_W-1:0]        str_sel;

  assign sample    = captured ? {1'b0, capture_count} : tmbd_pkg::MISSING_COUNT;
  assign cell_addr = CELL_W'(int'(string_idx) * NUM_FRETS + int'(fret_idx));
  assign str_sel   = STR_IDX_W'(string_idx);

  // baseline memory; entries never written since reset read as zero
  logic [NUM_CELLS-1:0]        base_valid;
  logic                        rd_valid;
  logic                        ram_we;
  logic [tmbd_pkg::BASE_W-1:0] ram_wdata;
  logic [tmbd_pkg::BASE_W-1:0] ram_rdata;
  logic [tmbd_pkg::BASE_W-1:0] base;
  logic                        touched;
  logic [tmbd_pkg::ACC_W-1:0]  acc;

  assign ram_we    = cmd.load_write || (cmd.update && !touched);
  assign ram_wdata = cmd.load_write ? sample : acc[tmbd_pkg::BASE_W-1:0];

  tmbd_ram #(
    .WIDTH (tmbd_pkg::BASE_W),
    .DEPTH (NUM_CELLS),
    .ADDR_W(CELL_W)
  ) u_baseline_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(cell_addr),
    .wdata(ram_wdata),
    .re   (cmd.read),
    .raddr(cell_addr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      base_valid <= '0;
    end else if (ram_we) begin
      base_valid[cell_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_valid <= base_valid[cell_addr];
    end
  end

  assign base = rd_valid ? ram_rdata : '0;

  // threshold compare and weighted sum
  logic [tmbd_pkg::BASE_W:0]    limit;
  logic                         touch_hit;
  logic [tmbd_pkg::PROD_W-1:0]  prod;

  assign limit     = {1'b0, base} + {1'b0, touch_threshold};
  assign touch_hit = {1'b0, sample} > limit;
  assign prod      = base * filter_weight;

  // restoring divide by 1 + weight, one quotient bit per cycle
  logic [tmbd_pkg::DIVISOR_W-1:0] divisor;
  logic [tmbd_pkg::DIVISOR_W-1:0] rem;
  logic [tmbd_pkg::DIVISOR_W:0]   trial;
  logic                           q_bit;
  logic [tmbd_pkg::DIV_CNT_W-1:0] div_cnt;

  assign divisor = {1'b0, filter_weight} + tmbd_pkg::DIVISOR_W'(1);
  assign trial   = {rem, acc[tmbd_pkg::ACC_W-1]};
  assign q_bit   = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      touched <= touch_hit;
      acc     <= tmbd_pkg::ACC_W'(prod) + tmbd_pkg::ACC_W'(sample);
      rem     <= '0;
      div_cnt <= tmbd_pkg::DIV_CNT_W'(tmbd_pkg::ACC_W - 1);
    end else if (cmd.div_step) begin
      acc     <= {acc[tmbd_pkg::ACC_W-2:0], q_bit};
      rem     <= q_bit ? tmbd_pkg::DIVISOR_W'(trial - {1'b0, divisor})
                       : trial[tmbd_pkg::DIVISOR_W-1:0];
      div_cnt <= div_cnt - tmbd_pkg::DIV_CNT_W'(1);
    end
  end

  // touch mask of the string being scanned
  logic [NUM_FRETS-1:0] touch_mask;
  logic                 last_fret;

  assign last_fret = int'(fret_idx) == NUM_FRETS - 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      touch_mask <= '0;
    end else if (cmd.update) begin
      if (fret_idx == '0) begin
        touch_mask <= {{(NUM_FRETS-1){1'b0}}, touched};
      end else begin
        for (int j = 1; j < NUM_FRETS; j++) begin
          if (int'(fret_idx) == j) touch_mask[j] <= touched;
        end
      end
    end
  end

  // open string history per string
  logic [HISTORY_WIDTH-1:0] history [NUM_STRINGS];
  logic [HISTORY_WIDTH-1:0] history_next;

  generate
    if (HISTORY_WIDTH > 1) begin : g_hist_shift
      assign history_next = {history[str_sel][HISTORY_WIDTH-2:0], touch_mask[0]};
    end else begin : g_hist_bit
      assign history_next = touch_mask[0];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_STRINGS; i++) history[i] <= '0;
    end else if (cmd.emit) begin
      history[str_sel] <= history_next;
    end
  end

  // result fields
  logic [tmbd_pkg::FRET_W-1:0]     fret_position;
  logic [tmbd_pkg::HIST_OUT_W-1:0] hist_out;
  logic [tmbd_pkg::MASK_OUT_W-1:0] mask_out;

  always_comb begin
    fret_position = '0;
    for (int j = NUM_FRETS - 1; j >= 1; j--) begin
      if (touch_mask[j]) fret_position = tmbd_pkg::FRET_W'(j);
    end
  end

  always_comb begin
    hist_out = '0;
    for (int i = 0; i < tmbd_pkg::HIST_OUT_W; i++) begin
      if (i < HISTORY_WIDTH) hist_out[i] = history_next[i];
    end
  end

  always_comb begin
    mask_out = '0;
    for (int i = 0; i < tmbd_pkg::MASK_OUT_W; i++) begin
      if (i < NUM_FRETS) mask_out[i] = touch_mask[i];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= {3'b000, mask_out, hist_out, fret_position, string_idx};
    end
  end

  assign status.in_range  = (int'(string_idx) < NUM_STRINGS) && (int'(fret_idx) < NUM_FRETS);
  assign status.is_load   = action == tmbd_pkg::ACTION_LOAD;
  assign status.touch_hit = touch_hit;
  assign status.div_done  = div_cnt == '0;
  assign status.last_fret = last_fret;
  assign status.out_busy  = m_tvalid && !m_tready;

endmodule

// ----- rtl/touch_matrix_baseline_detector.sv -----
// ----------------------------------------------------------------------------
// touch_matrix_baseline_detector
// capacitive touch detection with per-cell baseline tracking
// ----------------------------------------------------------------------------
// One item carries one capture for one (string, fret) cell; a cleared
// captured flag substitutes the count 99999. A load item copies the sample
// into the cell baseline. An evaluate item compares the sample against
// baseline plus touch_threshold and, when not touched, moves the baseline to
// (baseline*weight + sample)/(1 + weight), truncated. The divide is bit
// serial over the 26-bit weighted sum and runs only for an untouched
// evaluate. On the last fret the result goes to the output register,
// waiting while that register is still held by the sink. Items are
// processed one at a time. Frets are expected in order 0 to NUM_FRETS-1;
// the last fret yields one result item with the lowest touched fret above
// zero (zero if none), the string's open string history and its touch
// mask. Baselines read as zero after reset through per-cell valid flags, so
// no clearing pass is needed. Items with out-of-range indexes are dropped.
// ----------------------------------------------------------------------------
module touch_matrix_baseline_detector #(
  parameter int NUM_STRINGS   = tmbd_pkg::NUM_STRINGS_DEF,
  parameter int NUM_FRETS     = tmbd_pkg::NUM_FRETS_DEF,
  parameter int HISTORY_WIDTH = tmbd_pkg::HISTORY_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // input items
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // string_index[2:0], fret_index[5:3], capture_count[21:6], zero pad
  input  logic [tmbd_pkg::S_TDATA_W-1:0]  s_tdata,
  // action[0], captured[1]
  input  logic [tmbd_pkg::S_TUSER_W-1:0]  s_tuser,
  // result items
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // string_index_out[2:0], fret_position[5:3], open_string_history[13:6],
  // touch_mask[20:14], zero pad
  output logic [tmbd_pkg::M_TDATA_W-1:0]  m_tdata,
  // configuration
  input  logic                            cfg_we,
  input  logic [tmbd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tmbd_pkg::CFG_DATA_W-1:0] cfg_data
);

  tmbd_pkg::ctrl_cmd_t    cmd;
  tmbd_pkg::ctrl_status_t status;

  tmbd_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .status  (status),
    .cmd     (cmd)
  );

  tmbd_datapath #(
    .NUM_STRINGS  (NUM_STRINGS),
    .NUM_FRETS    (NUM_FRETS),
    .HISTORY_WIDTH(HISTORY_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

endmodule

// ----- tb/sv/touch_matrix_baseline_detector_tb.sv -----
// ----------------------------------------------------------------------------
// touch_matrix_baseline_detector_tb
// Self-checking bench for the touch matrix baseline detector. Scan items go
// in through the input stream and string results come back on the output
// stream. Each result is checked field by field against a behavioral model
// of baseline tracking, touch masks and open string history, or against the
// expected result in the short table of directed items that comes first.
// Random scans follow over several threshold and weight settings, with
// random idle on the input side and random backpressure on the output side.
// ----------------------------------------------------------------------------
module touch_matrix_baseline_detector_tb;

  localparam int STRING_W   = tmbd_pkg::STRING_W;
  localparam int FRET_W     = tmbd_pkg::FRET_W;
  localparam int COUNT_W    = tmbd_pkg::COUNT_W;
  localparam int HIST_OUT_W = tmbd_pkg::HIST_OUT_W;
  localparam int MASK_OUT_W = tmbd_pkg::MASK_OUT_W;
  localparam int BASE_W     = tmbd_pkg::BASE_W;
  localparam int WEIGHT_W   = tmbd_pkg::WEIGHT_W;
  localparam int S_TDATA_W  = tmbd_pkg::S_TDATA_W;
  localparam int S_TUSER_W  = tmbd_pkg::S_TUSER_W;
  localparam int M_TDATA_W  = tmbd_pkg::M_TDATA_W;
  localparam int CFG_IDX_W  = tmbd_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = tmbd_pkg::CFG_DATA_W;

  localparam logic [BASE_W-1:0]    MISSING_COUNT   = tmbd_pkg::MISSING_COUNT;
  localparam logic [BASE_W-1:0]    THRESHOLD_RESET = tmbd_pkg::THRESHOLD_RESET;
  localparam logic [WEIGHT_W-1:0]  WEIGHT_RESET    = tmbd_pkg::WEIGHT_RESET;
  localparam logic                 ACTION_EVALUATE = tmbd_pkg::ACTION_EVALUATE;
  localparam logic                 ACTION_LOAD     = tmbd_pkg::ACTION_LOAD;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = tmbd_pkg::REG_THRESHOLD;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT      = tmbd_pkg::REG_WEIGHT;

  localparam int NSTR       = tmbd_pkg::NUM_STRINGS_DEF;
  localparam int NFRET      = tmbd_pkg::NUM_FRETS_DEF;
  localparam int NUM_PHASES = 8;
  localparam int ITEM_GOAL  = 1950;
  localparam int HOLDOFF    = 48;
  localparam int CYCLE_CAP  = 1000000;
  localparam int DRILL_LEN  = 25;

  typedef struct packed {
    logic                action;
    logic [STRING_W-1:0] str;
    logic [FRET_W-1:0]   fret;
    logic                cap;
    logic [COUNT_W-1:0]  count;
  } scan_item_t;

  typedef struct packed {
    logic [STRING_W-1:0]   str;
    logic [FRET_W-1:0]     pos;
    logic [HIST_OUT_W-1:0] hist;
    logic [MASK_OUT_W-1:0] mask;
  } string_result_t;

  typedef struct packed {
    scan_item_t     item;
    logic           typed;
    string_result_t res;
  } drill_row_t;

  localparam string_result_t NO_RESULT = '0;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [S_TUSER_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  touch_matrix_baseline_detector u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model state
  logic [BASE_W-1:0]     base_mem [NSTR*NFRET];
  logic [NFRET-1:0]      frets_touched;
  logic [HIST_OUT_W-1:0] open_hist [NSTR];
  logic [BASE_W-1:0]     touch_threshold_q = THRESHOLD_RESET;
  logic [WEIGHT_W-1:0]   filter_weight_q = WEIGHT_RESET;

  string_result_t pending_results [$];
  int idle_pct = 0;
  int stall_pct = 0;
  int scanned_items = 0;
  int ignored_items = 0;
  int results_seen = 0;
  int fail_count = 0;
  int cycles = 0;

  int phase_thr    [0:NUM_PHASES-1] = '{200, 0, 131071, 1000, 50, 5000, 200, 0};
  int phase_weight [0:NUM_PHASES-1] = '{50, 0, 255, 1, 200, 8, 50, 0};
  int phase_idle   [0:NUM_PHASES-1] = '{0, 55, 0, 9, 0, 55, 0, 9};
  int phase_stall  [0:NUM_PHASES-1] = '{0, 0, 55, 9, 0, 0, 55, 9};

  drill_row_t drill_plan [0:DRILL_LEN-1] = '{
    '{'{ACTION_EVALUATE, 3'd0, 3'd0, 1'b1, 16'd0}, 1'b0, NO_RESULT},
    '{'{ACTION_EVALUATE, 3'd0, 3'd1, 1'b1, 16'd0}, 1'b0, NO_RESULT},
    '{'{ACTION_EVALUATE, 3'd0, 3'd2, 1'b1, 16'd0}, 1'b0, NO_RESULT},
    '{'{ACTION_EVALUATE, 3'd0, 3'd3, 1'b1, 16'd0}, 1'b0, NO_RESULT},
    '{'{ACTION_EVALUATE, 3'd0, 3'd4, 1'b1, 16'd0}, 1'b0, NO_RESULT},
    '{'{ACTION_EVALUATE, 3'd0, 3'd5, 1'b1, 16'd0}, 1'b0, NO_RESULT},
    '{'{ACTION_EVALUATE, 3'd0, 3'd6, 1'b1, 16'd0}, 1'b1, '{3'd0, 3'd0, 8'h00, 7'h00}},
    '{'{ACTION_EVALUATE, 3'd5, 3'd0, 1'b0, 16'd0}, 1'b0, NO_RESULT},
    '{'{ACTION_EVALUATE, 3'd5, 3'd1, 1'b0, 16'd0}, 1'b0, NO_RESULT},
    '{'{ACTION_EVALUATE, 3'd5, 3'd2, 1'b0, 16'd0}, 1'b0, NO_RESULT},
    '{'{ACTION_EVALUATE, 3'd5, 3'd3, 1'b0, 16'd0}, 1'b0, NO_RESULT},
    '{'{ACTION_EVALUATE, 3'd5, 3'd4, 1'b0, 16'd0}, 1'b0, NO_RESULT},
    '{'{ACTION_EVALUATE, 3'd5, 3'd5, 1'b0, 16'd0}, 1'b0, NO_RESULT},
    '{'{ACTION_EVALUATE, 3'd5, 3'd6, 1'b0, 16'd0}, 1'b1, '{3'd5, 3'd1, 8'h01, 7'h7F}},
    '{'{ACTION_LOAD,     3'd1, 3'd6, 1'b1, 16'hFFFF}, 1'b0, NO_RESULT},
    '{'{ACTION_LOAD,     3'd1, 3'd0, 1'b0, 16'd0}, 1'b0, NO_RESULT},
    '{'{ACTION_EVALUATE, 3'd6, 3'd0, 1'b1, 16'd1000}, 1'b0, NO_RESULT},
    '{'{ACTION_LOAD,     3'd7, 3'd7, 1'b1, 16'hFFFF}, 1'b0, NO_RESULT},
    '{'{ACTION_EVALUATE, 3'd0, 3'd7, 1'b0, 16'd0}, 1'b0, NO_RESULT},
    '{'{ACTION_EVALUATE, 3'd1, 3'd3, 1'b1, 16'd300}, 1'b0, NO_RESULT},
    '{'{ACTION_EVALUATE, 3'd1, 3'd6, 1'b1, 16'hFFFF}, 1'b1, '{3'd1, 3'd1, 8'h01, 7'h3F}},
    '{'{ACTION_EVALUATE, 3'd1, 3'd0, 1'b0, 16'd0}, 1'b0, NO_RESULT},
    '{'{ACTION_EVALUATE, 3'd2, 3'd1, 1'b1, 16'd200}, 1'b0, NO_RESULT},
    '{'{ACTION_EVALUATE, 3'd2, 3'd2, 1'b1, 16'd201}, 1'b0, NO_RESULT},
    '{'{ACTION_EVALUATE, 3'd2, 3'd6, 1'b1, 16'd0}, 1'b0, NO_RESULT}
  };

  function automatic bit predict_scan(input scan_item_t it, output string_result_t res);
    logic [BASE_W-1:0] sample;
    int cell_addr;
    int bv;
    int sv;
    int wv;
    int tv;
    bit hit;
    logic [FRET_W-1:0] pos;
    res = '0;
    if (it.str >= NSTR || it.fret >= NFRET) return 1'b0;
    sample = it.cap ? BASE_W'(it.count) : MISSING_COUNT;
    cell_addr = it.str * NFRET + it.fret;
    if (it.action == ACTION_LOAD) begin
      base_mem[cell_addr] = sample;
      return 1'b0;
    end
    bv = base_mem[cell_addr];
    sv = sample;
    wv = filter_weight_q;
    tv = touch_threshold_q;
    hit = (sv - bv) > tv;
    if (!hit) base_mem[cell_addr] = BASE_W'((bv * wv + sv) / (wv + 1));
    if (it.fret == 0) frets_touched = NFRET'(hit);
    else frets_touched[it.fret] = hit;
    if (it.fret != NFRET - 1) return 1'b0;
    open_hist[it.str] = {open_hist[it.str][HIST_OUT_W-2:0], frets_touched[0]};
    pos = '0;
    for (int j = NFRET - 1; j >= 1; j--) begin
      if (frets_touched[j]) pos = FRET_W'(j);
    end
    res = '{it.str, pos, open_hist[it.str], MASK_OUT_W'(frets_touched)};
    return 1'b1;
  endfunction

  // evaluate item aimed around the cell baseline so touches come and go
  function automatic scan_item_t eval_item(input int s, input int f);
    scan_item_t it;
    int bv;
    int tv;
    int c;
    int pick;
    bv = base_mem[s * NFRET + f];
    tv = touch_threshold_q;
    pick = $urandom_range(0, 9);
    if (pick < 4) c = bv + tv + 1 + int'($urandom_range(0, 40));
    else if (pick == 4) c = bv + tv;
    else c = bv + int'($urandom_range(0, tv)) - int'($urandom_range(0, 100));
    if (c < 0) c = 0;
    it.action = ACTION_EVALUATE;
    it.str = STRING_W'(s);
    it.fret = FRET_W'(f);
    it.cap = 1'b1;
    it.count = COUNT_W'(c);
    if (c > 65535 || $urandom_range(0, 19) == 0) begin
      it.cap = 1'b0;
      it.count = COUNT_W'($urandom);
    end
    return it;
  endfunction

  task automatic send_item(input scan_item_t it, input bit typed, input string_result_t typed_res);
    string_result_t res;
    bit emits;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata <= S_TDATA_W'({it.count, it.fret, it.str});
    s_tuser <= {it.cap, it.action};
    do @(posedge clk); while (!s_tready);
    emits = predict_scan(it, res);
    if (it.str >= NSTR || it.fret >= NFRET) ignored_items++;
    else scanned_items++;
    if (emits) pending_results.push_back(typed ? typed_res : res);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (HOLDOFF) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_THRESHOLD) touch_threshold_q = BASE_W'(val);
    else filter_weight_q = WEIGHT_W'(val);
  endtask

  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin : result_check
    string_result_t got;
    string_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tdata[2:0], m_tdata[5:3], m_tdata[13:6], m_tdata[20:14]};
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result item with none expected: string %0d mask %h", got.str, got.mask);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.str !== want.str) begin
          $error("string_index_out: expected %0d, got %0d", want.str, got.str);
          fail_count++;
        end
        if (got.pos !== want.pos) begin
          $error("fret_position: expected %0d, got %0d", want.pos, got.pos);
          fail_count++;
        end
        if (got.hist !== want.hist) begin
          $error("open_string_history: expected %h, got %h", want.hist, got.hist);
          fail_count++;
        end
        if (got.mask !== want.mask) begin
          $error("touch_mask: expected %h, got %h", want.mask, got.mask);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("[touch_matrix_baseline_detector] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    scan_item_t it;
    int kind;
    int s;
    int n;
    int target;
    for (int i = 0; i < NSTR * NFRET; i++) base_mem[i] = '0;
    for (int i = 0; i < NSTR; i++) open_hist[i] = '0;
    frets_touched = '0;
    phase_thr[NUM_PHASES-1] = $urandom_range(0, 3000);
    phase_weight[NUM_PHASES-1] = $urandom_range(0, 255);
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DRILL_LEN; i++)
      send_item(drill_plan[i].item, drill_plan[i].typed, drill_plan[i].res);

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      write_reg(REG_THRESHOLD, phase_thr[p]);
      write_reg(REG_WEIGHT, phase_weight[p]);
      idle_pct = phase_idle[p];
      stall_pct = phase_stall[p];
      target = DRILL_LEN + (p + 1) * ITEM_GOAL / NUM_PHASES;
      while (scanned_items < target) begin
        kind = $urandom_range(0, 99);
        if (kind < 15) begin
          s = $urandom_range(0, NSTR - 1);
          for (int f = 0; f < NFRET; f++) begin
            it.action = ACTION_LOAD;
            it.str = STRING_W'(s);
            it.fret = FRET_W'(f);
            it.cap = ($urandom_range(0, 9) != 0);
            it.count = COUNT_W'($urandom);
            send_item(it, 1'b0, NO_RESULT);
          end
        end else if (kind < 75) begin
          s = $urandom_range(0, NSTR - 1);
          for (int f = 0; f < NFRET; f++) send_item(eval_item(s, f), 1'b0, NO_RESULT);
        end else if (kind < 90) begin
          n = $urandom_range(1, 8);
          repeat (n) begin
            it = eval_item($urandom_range(0, NSTR - 1), $urandom_range(0, NFRET - 1));
            if ($urandom_range(0, 7) == 0) it.action = ACTION_LOAD;
            send_item(it, 1'b0, NO_RESULT);
          end
        end else begin
          n = $urandom_range(1, 4);
          repeat (n) begin
            it.action = 1'($urandom_range(0, 1));
            it.str = STRING_W'($urandom_range(0, 7));
            it.fret = FRET_W'($urandom_range(0, 7));
            it.cap = 1'($urandom_range(0, 1));
            it.count = COUNT_W'($urandom);
            send_item(it, 1'b0, NO_RESULT);
          end
        end
        if ($urandom_range(0, 299) == 0) settle();
      end
    end

    settle();
    $display("%0d scan items sent (%0d with out-of-range indexes), %0d register settings",
             scanned_items + ignored_items, ignored_items, NUM_PHASES + 1);
    $display("%0d string results checked, %0d mismatches", results_seen, fail_count);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("[touch_matrix_baseline_detector] OK");
    end else begin
      $display("[touch_matrix_baseline_detector] ERROR");
    end
    $finish;
  end

endmodule
